// File: rtl/pcm_rms_level_meter_db_top_defines.svh
// assertion macros shared by the level meter modules
`ifndef PCM_RMS_LEVEL_METER_DB_TOP_DEFINES_SVH
`define PCM_RMS_LEVEL_METER_DB_TOP_DEFINES_SVH

// condition must never hold while out of reset
`define PRLM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define PRLM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/prlm_pkg.sv
// shared types and constants of the pcm rms level meter
package prlm_pkg;

  // square of one centred sample magnitude (at most 2**30)
  localparam int SQ_W = 31;
  // mantissa width of the log2 unit
  localparam int MANT_W = 32;

  // 8-bit mode centre value
  localparam logic [7:0] CENTER_8 = 8'd127;

  // squared full-scale divisors
  localparam int DSQ_W = 30;
  localparam logic [DSQ_W-1:0] DSQ_8BIT = 30'd16129;
  localparam logic [DSQ_W-1:0] DSQ_16BIT = 30'd1073676289;

  // 10*log10(2) in q16
  localparam int DB_W = 18;
  localparam logic [DB_W-1:0] DB_PER_LOG2_Q16 = 18'd197283;

  // level arithmetic
  localparam logic [10:0] Q_CLAMP = 11'd1000;
  localparam logic signed [11:0] LEVEL_OFFSET = 12'sd35;
  localparam logic signed [11:0] LEVEL_MIN = -12'sd128;
  localparam logic signed [11:0] LEVEL_MAX = 12'sd127;
  localparam logic signed [7:0] LEVEL_FLOOR = 8'sh80;
  localparam logic signed [7:0] LEVEL_CEIL = 8'sh7f;
  localparam logic signed [7:0] LEVEL_SILENT = 8'sh00;
  localparam logic [5:0] FULL_SCALE = 6'd40;
  localparam logic [5:0] FULL_SCALE_SILENT = 6'd0;

  // per-buffer flags carried with a finished buffer
  typedef struct packed {
    logic sixteen_bit;
    logic silent;
  } job_flags_t;

endpackage

// File: rtl/prlm_front.sv
// front end: sample centring, squaring and per-buffer accumulation
module prlm_front #(
  parameter int unsigned MAX_SAMPLES = 65536,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W = prlm_pkg::SQ_W - 1 + CNT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              in_sample,
  input  logic                     in_silent,
  input  logic                     in_last,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [SUM_W-1:0]         push_sum,
  output logic [CNT_W-1:0]         push_count,
  output prlm_pkg::job_flags_t     push_flags
);
  import prlm_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  logic             mode_r;
  logic             s1_valid_r;
  logic [SQ_W-1:0]  s1_sq_r;
  logic             s1_last_r;
  logic             s1_silent_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] count_r;
  logic             silent_r;

  logic [15:0]      mag;
  logic [31:0]      sq_full;
  logic             acc_en;
  logic             s1_adv;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] count_add;
  logic             silent_add;

  // mode register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // centre the sample and take its magnitude
  always_comb begin
    if (mode_r) begin
      mag = in_sample[15] ? (~in_sample + 16'd1) : in_sample;
    end else if (in_sample[7:0] >= CENTER_8) begin
      mag = {8'd0, in_sample[7:0] - CENTER_8};
    end else begin
      mag = {8'd0, CENTER_8 - in_sample[7:0]};
    end
  end

  assign sq_full = 32'(mag) * 32'(mag);

  // accumulate stage
  assign acc_en     = s1_valid_r && (count_r < MAX_CNT);
  assign sum_add    = acc_en ? sum_r + SUM_W'(s1_sq_r) : sum_r;
  assign count_add  = acc_en ? count_r + CNT_W'(1) : count_r;
  assign silent_add = silent_r | s1_silent_r;
  assign s1_adv     = s1_valid_r && (!s1_last_r || push_ready);
  assign in_ready   = !s1_valid_r || s1_adv;

  // finished buffer goes to the queue
  assign push_valid              = s1_valid_r && s1_last_r;
  assign push_sum                = sum_add;
  assign push_count              = count_add;
  assign push_flags.sixteen_bit  = mode_r;
  assign push_flags.silent       = silent_add;

  // square register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_sq_r     <= sq_full[SQ_W-1:0];
      s1_last_r   <= in_last;
      s1_silent_r <= in_silent;
    end
  end

  // running sums, cleared at the end of each buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      count_r  <= '0;
      silent_r <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        sum_r    <= '0;
        count_r  <= '0;
        silent_r <= 1'b0;
      end else begin
        sum_r    <= sum_add;
        count_r  <= count_add;
        silent_r <= silent_add;
      end
    end
  end

endmodule

// File: rtl/prlm_queue.sv
// two-entry queue of finished buffers between front and back
`include "pcm_rms_level_meter_db_top_defines.svh"

module prlm_queue #(
  parameter int WIDTH = 66
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;
  logic             push;
  logic             pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `PRLM_ASSERT_NEVER(a_fill_range, fill_r == 2'd3, "queue fill level out of range")
  `PRLM_ASSERT_NEXT(a_fill_up, push && !pop, fill_r == $past(fill_r) + 2'd1, "fill not raised")
  `PRLM_ASSERT_IMPL(a_ptr_track, fill_r == 2'd0, wr_ptr_r == rd_ptr_r, "empty queue ptr skew")

endmodule

// File: rtl/prlm_log2.sv
// iterative fixed-point log2 unit: normalize, then one squaring per fraction bit
module prlm_log2 #(
  parameter int NW = 47,
  parameter int FRAC_W = 16,
  localparam int TOP_W = $clog2(NW),
  localparam int LOG_W = TOP_W + FRAC_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NW-1:0]    value,
  output logic             done,
  output logic [LOG_W-1:0] result
);
  import prlm_pkg::*;

  localparam int IT_W = $clog2(FRAC_W);

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_FRAC
  } lstate_t;

  lstate_t             state_r, state_nxt;
  logic [NW-1:0]       norm_r, norm_nxt;
  logic [TOP_W-1:0]    shift_r, shift_nxt;
  logic [MANT_W-1:0]   m_r, m_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [IT_W-1:0]     iter_r, iter_nxt;
  logic                done_r, done_nxt;
  logic [2*MANT_W-1:0] m_sq;
  logic [MANT_W:0]     m_sq_top;

  assign m_sq     = (2*MANT_W)'(m_r) * (2*MANT_W)'(m_r);
  assign m_sq_top = m_sq[2*MANT_W-1:MANT_W-1];

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    norm_nxt  = norm_r;
    shift_nxt = shift_r;
    m_nxt     = m_r;
    frac_nxt  = frac_r;
    iter_nxt  = iter_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          norm_nxt  = value;
          shift_nxt = '0;
          state_nxt = L_NORM;
        end
      end
      L_NORM: begin
        if (norm_r[NW-1]) begin
          m_nxt     = norm_r[NW-1 -: MANT_W];
          frac_nxt  = '0;
          iter_nxt  = '0;
          state_nxt = L_FRAC;
        end else if (norm_r[NW-1 -: 8] == 8'd0) begin
          norm_nxt  = norm_r << 8;
          shift_nxt = shift_r + TOP_W'(8);
        end else begin
          norm_nxt  = norm_r << 1;
          shift_nxt = shift_r + TOP_W'(1);
        end
      end
      L_FRAC: begin
        if (m_sq_top[MANT_W]) begin
          m_nxt    = m_sq_top[MANT_W:1];
          frac_nxt = {frac_r[FRAC_W-2:0], 1'b1};
        end else begin
          m_nxt    = m_sq_top[MANT_W-1:0];
          frac_nxt = {frac_r[FRAC_W-2:0], 1'b0};
        end
        iter_nxt = iter_r + IT_W'(1);
        if (iter_r == IT_W'(FRAC_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    norm_r  <= norm_nxt;
    shift_r <= shift_nxt;
    m_r     <= m_nxt;
    frac_r  <= frac_nxt;
    iter_r  <= iter_nxt;
  end

  assign done   = done_r;
  assign result = {TOP_W'(NW - 1) - shift_r, frac_r};

endmodule

// File: rtl/prlm_back.sv
// back end: log2 sequencing, decibel scaling and result register
`include "pcm_rms_level_meter_db_top_defines.svh"

module prlm_back #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int LOG_FRACTION_BITS = 16,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W = prlm_pkg::SQ_W - 1 + CNT_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  logic [SUM_W-1:0]     pop_sum,
  input  logic [CNT_W-1:0]     pop_count,
  input  prlm_pkg::job_flags_t pop_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [7:0]    out_level,
  output logic [5:0]           out_full_scale
);
  import prlm_pkg::*;

  localparam int NW     = (SUM_W > 32) ? SUM_W : 32;
  localparam int TOP_W  = $clog2(NW);
  localparam int LOG_W  = TOP_W + LOG_FRACTION_BITS;
  localparam int MAG_W  = LOG_W + 1;
  localparam int PROD_W = MAG_W + DB_W;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LSUM,
    B_LCNT,
    B_LDSQ,
    B_DIFF,
    B_MULT,
    B_FIN,
    B_WRITE
  } bstate_t;

  bstate_t            state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               mode_r, mode_nxt;
  logic               log_start_r, log_start_nxt;
  logic [NW-1:0]      log_value_r, log_value_nxt;
  logic [MAG_W-1:0]   pos_r, pos_nxt;
  logic [MAG_W-1:0]   neg_r, neg_nxt;
  logic               negative_r, negative_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [7:0]  res_level_r, res_level_nxt;
  logic [5:0]         res_fs_r, res_fs_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [7:0]  out_level_r, out_level_nxt;
  logic [5:0]         out_fs_r, out_fs_nxt;

  logic               pop;
  logic               log_done;
  logic [LOG_W-1:0]   log_result;
  logic [DSQ_W-1:0]   dsq;
  logic [15:0]        q_full;
  logic [10:0]        q_clamped;
  logic signed [11:0] level_wide;
  logic signed [7:0]  level_sat;

  assign pop_ready = (state_r == B_IDLE);
  assign pop       = pop_valid && pop_ready;
  assign dsq       = mode_r ? DSQ_16BIT : DSQ_8BIT;

  // shared log2 unit
  prlm_log2 #(
    .NW     (NW),
    .FRAC_W (LOG_FRACTION_BITS)
  ) u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start_r),
    .value  (log_value_r),
    .done   (log_done),
    .result (log_result)
  );

  // whole-db quotient, clamp, offset and saturation
  always_comb begin
    q_full    = 16'(prod_r >> (LOG_FRACTION_BITS + 16));
    q_clamped = (q_full > 16'(Q_CLAMP)) ? Q_CLAMP : q_full[10:0];
    if (negative_r) begin
      level_wide = LEVEL_OFFSET - $signed({1'b0, q_clamped});
    end else begin
      level_wide = LEVEL_OFFSET + $signed({1'b0, q_clamped});
    end
    if (level_wide < LEVEL_MIN) begin
      level_sat = LEVEL_FLOOR;
    end else if (level_wide > LEVEL_MAX) begin
      level_sat = LEVEL_CEIL;
    end else begin
      level_sat = $signed(level_wide[7:0]);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    log_start_nxt = 1'b0;
    log_value_nxt = log_value_r;
    pos_nxt       = pos_r;
    neg_nxt       = neg_r;
    negative_nxt  = negative_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    res_level_nxt = res_level_r;
    res_fs_nxt    = res_fs_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    out_fs_nxt    = out_fs_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop) begin
          count_nxt = pop_count;
          mode_nxt  = pop_flags.sixteen_bit;
          if (pop_flags.silent) begin
            res_level_nxt = LEVEL_SILENT;
            res_fs_nxt    = FULL_SCALE_SILENT;
            state_nxt     = B_WRITE;
          end else if (pop_sum == '0 || pop_count == '0) begin
            // no energy in the buffer
            res_level_nxt = LEVEL_FLOOR;
            res_fs_nxt    = FULL_SCALE;
            state_nxt     = B_WRITE;
          end else begin
            log_start_nxt = 1'b1;
            log_value_nxt = NW'(pop_sum);
            state_nxt     = B_LSUM;
          end
        end
      end
      B_LSUM: begin
        if (log_done) begin
          pos_nxt       = MAG_W'(log_result);
          log_start_nxt = 1'b1;
          log_value_nxt = NW'(count_r);
          state_nxt     = B_LCNT;
        end
      end
      B_LCNT: begin
        if (log_done) begin
          neg_nxt       = MAG_W'(log_result);
          log_start_nxt = 1'b1;
          log_value_nxt = NW'(dsq);
          state_nxt     = B_LDSQ;
        end
      end
      B_LDSQ: begin
        if (log_done) begin
          neg_nxt   = neg_r + MAG_W'(log_result);
          state_nxt = B_DIFF;
        end
      end
      B_DIFF: begin
        negative_nxt = neg_r > pos_r;
        mag_nxt      = (neg_r > pos_r) ? neg_r - pos_r : pos_r - neg_r;
        state_nxt    = B_MULT;
      end
      B_MULT: begin
        prod_nxt  = PROD_W'(mag_r) * PROD_W'(DB_PER_LOG2_Q16);
        state_nxt = B_FIN;
      end
      B_FIN: begin
        res_level_nxt = level_sat;
        res_fs_nxt    = FULL_SCALE;
        state_nxt     = B_WRITE;
      end
      B_WRITE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = res_level_r;
          out_fs_nxt    = res_fs_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      log_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      log_start_r <= log_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    count_r     <= count_nxt;
    mode_r      <= mode_nxt;
    log_value_r <= log_value_nxt;
    pos_r       <= pos_nxt;
    neg_r       <= neg_nxt;
    negative_r  <= negative_nxt;
    mag_r       <= mag_nxt;
    prod_r      <= prod_nxt;
    res_level_r <= res_level_nxt;
    res_fs_r    <= res_fs_nxt;
    out_level_r <= out_level_nxt;
    out_fs_r    <= out_fs_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_full_scale = out_fs_r;

  `PRLM_ASSERT_IMPL(a_silent_zero, out_valid_r && (out_fs_r == FULL_SCALE_SILENT), out_level_r == LEVEL_SILENT, "silent word with nonzero level")
  `PRLM_ASSERT_NEXT(a_pop_busy, pop, state_r != B_IDLE, "buffer taken but engine idle")
  `PRLM_ASSERT_IMPL(a_log_in_run, log_start_r, state_r == B_LSUM || state_r == B_LCNT || state_r == B_LDSQ, "log2 started outside a log step")

endmodule

// File: rtl/pcm_rms_level_meter_db_top.sv
// top level of the pcm rms level meter
//
// Samples of one buffer enter on the in_ channel (valid/ready), one word per
// clock; in_last marks the final sample and in_silent marks the whole buffer
// silent. For each buffer one word leaves on the out_ channel: out_level is
// 35 plus the truncated rms in dB (two's complement, -128 for zero energy)
// and out_full_scale is 40, or both are 0 for a silent buffer.
// The cfg_ channel writes the sample format (0: 8-bit unsigned, 1: 16-bit
// signed); write it only while no buffer is in flight.
// Throughput: one sample per clock inside a buffer. A finished buffer waits
// in a two-entry queue for the level engine, which runs three log2 passes on
// one shared unit (each a start step, a normalize phase, one squaring step
// per fraction bit and a done step) and then the difference, multiply, finish
// and write states for scaling and output. The input stalls only when two
// finished buffers are already queued.
// Synchronous active-low reset clears the sums, the queue, the engine and the
// format register. While out_ready is low the result word holds and the
// engine waits, but sample accumulation continues.
module pcm_rms_level_meter_db_top #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int LOG_FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_sample,
  input  logic              in_silent,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_level,
  output logic [5:0]        out_full_scale
);
  import prlm_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SQ_W - 1 + CNT_W;
  localparam int FLG_W = $bits(job_flags_t);
  localparam int JOB_W = FLG_W + CNT_W + SUM_W;

  logic             push_valid;
  logic             push_ready;
  logic [SUM_W-1:0] push_sum;
  logic [CNT_W-1:0] push_count;
  job_flags_t       push_flags;
  logic             pop_valid;
  logic             pop_ready;
  logic [JOB_W-1:0] pop_data;
  job_flags_t       pop_flags;

  // accumulation front end
  prlm_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_silent  (in_silent),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_sum   (push_sum),
    .push_count (push_count),
    .push_flags (push_flags)
  );

  // finished-buffer queue
  prlm_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_flags, push_count, push_sum}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_flags = job_flags_t'(pop_data[JOB_W-1 -: FLG_W]);

  // level engine
  prlm_back #(
    .MAX_SAMPLES       (MAX_SAMPLES),
    .LOG_FRACTION_BITS (LOG_FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_sum        (pop_data[SUM_W-1:0]),
    .pop_count      (pop_data[SUM_W +: CNT_W]),
    .pop_flags      (pop_flags),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level      (out_level),
    .out_full_scale (out_full_scale)
  );

endmodule
